// File: src/pkm_pkg.sv
`default_nettype none
package pkm_pkg;

    // Ring size default and the widest slot index the ring can need
    localparam int RING_DEPTH_DEF = 1024;
    localparam int SLOT_MAX_W     = 16;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Command codes
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // Constants
    localparam logic [31:0] MARKER_RESET = 32'h0000_1234;
    localparam logic [30:0] COUNT_MAX    = 31'h7FFF_FFFF;
    localparam logic signed [63:0] WIN_MIN_RESET = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] WIN_MAX_RESET = 64'sh8000_0000_0000_0000;
    localparam logic [31:0] PEAK_RESET   = 32'hFFFF_FFFF;
    localparam logic [31:0] SAT_POS      = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG      = 32'h8000_0000;

    // Classified word handed from front to back
    typedef struct packed {
        logic                  is_tick;
        logic [30:0]           seq;
        logic [62:0]           send;
        logic [62:0]           recv;
        logic [SLOT_MAX_W-1:0] slot;
    } pkm_op_t;

    // One ring entry
    typedef struct packed {
        logic        filled;
        logic [30:0] seq;
        logic [62:0] send;
        logic [62:0] recv;
    } pkm_entry_t;

    // Saturating increment of a 31-bit counter
    function automatic logic [30:0] sat_inc31(input logic [30:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 31'd1;
    endfunction

endpackage
`default_nettype wire

// File: src/pkm_ram.sv
`default_nettype none
module pkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// File: src/pkm_queue.sv
`default_nettype none
module pkm_queue
    import pkm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    input  wire pkm_op_t push_data,
    output logic         full,
    input  wire logic    pop,
    output pkm_op_t      pop_data,
    output logic         empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    pkm_op_t          entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign do_push  = push_valid && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// File: src/pkm_front.sv
`default_nettype none
module pkm_front
    import pkm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [31:0] marker_value,
    input  wire logic        hold,
    input  wire logic        pkt_valid,
    output logic             pkt_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] marker,
    input  wire logic [30:0] seq_num,
    input  wire logic [62:0] send_time,
    input  wire logic [62:0] recv_time,
    output logic             push_valid,
    output pkm_op_t          push_data,
    input  wire logic        q_full
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    // floor(2^32 / depth): quotient estimate is exact or one low
    localparam logic [31:0] RECIP   = 32'((64'd1 << 32) / 64'(RING_DEPTH));
    localparam logic [30:0] DEPTH31 = 31'(RING_DEPTH);

    typedef enum logic [3:0] {
        F_IDLE  = 4'b0001,
        F_MUL_Q = 4'b0010,
        F_MUL_D = 4'b0100,
        F_PUSH  = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;
    logic         is_tick_reg, is_tick_next;
    logic [30:0]  seq_reg, seq_next;
    logic [62:0]  send_reg, send_next;
    logic [62:0]  recv_reg, recv_next;
    logic [30:0]  q_reg, q_next;
    logic [30:0]  qd_reg, qd_next;
    logic [62:0]  prod;
    logic [30:0]  rem_raw, rem;

    assign pkt_stall = hold || (state_reg != F_IDLE);

    // Slot = seq mod depth by reciprocal multiply and one correction
    assign prod    = 63'(seq_reg) * 63'(RECIP);
    assign rem_raw = seq_reg - qd_reg;
    assign rem     = (rem_raw >= DEPTH31) ? rem_raw - DEPTH31 : rem_raw;

    assign push_data.is_tick = is_tick_reg;
    assign push_data.seq     = seq_reg;
    assign push_data.send    = send_reg;
    assign push_data.recv    = recv_reg;
    assign push_data.slot    = SLOT_MAX_W'(rem[SLOT_W-1:0]);

    // Accept, filter on marker, work out the slot, hand over
    always_comb
    begin
        state_next   = state_reg;
        is_tick_next = is_tick_reg;
        seq_next     = seq_reg;
        send_next    = send_reg;
        recv_next    = recv_reg;
        q_next       = q_reg;
        qd_next      = qd_reg;
        push_valid   = 1'b0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (pkt_valid && !hold)
                begin
                    seq_next  = seq_num;
                    send_next = send_time;
                    recv_next = recv_time;
                    if (cmd == CMD_TICK)
                    begin
                        is_tick_next = 1'b1;
                        state_next   = F_PUSH;
                    end
                    else if (marker == marker_value)
                    begin
                        is_tick_next = 1'b0;
                        state_next   = F_MUL_Q;
                    end
                end
            end
            F_MUL_Q:
            begin
                q_next     = prod[62:32];
                state_next = F_MUL_D;
            end
            F_MUL_D:
            begin
                qd_next    = q_reg * DEPTH31;
                state_next = F_PUSH;
            end
            F_PUSH:
            begin
                push_valid = 1'b1;
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= F_IDLE;
            is_tick_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            is_tick_reg <= is_tick_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg  <= seq_next;
        send_reg <= send_next;
        recv_reg <= recv_next;
        q_reg    <= q_next;
        qd_reg   <= qd_next;
    end

endmodule
`default_nettype wire

// File: src/pkm_back.sv
`default_nettype none
module pkm_back
    import pkm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        q_empty,
    input  wire pkm_op_t     q_data,
    output logic             q_pop,
    output logic             clearing,
    output logic             rpt_valid,
    input  wire logic        rpt_stall,
    output logic [30:0]      total_packets,
    output logic [30:0]      new_packets,
    output logic [31:0]      loss,
    output logic [31:0]      loss_change,
    output logic [31:0]      jitter_peak,
    output logic [31:0]      jitter_window
);

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(RING_DEPTH - 1);

    typedef enum logic [7:0] {
        B_CLEAR  = 8'b0000_0001,
        B_IDLE   = 8'b0000_0010,
        B_RD_NXT = 8'b0000_0100,
        B_RD_PRV = 8'b0000_1000,
        B_PAIR_N = 8'b0001_0000,
        B_PAIR_P = 8'b0010_0000,
        B_TICK_A = 8'b0100_0000,
        B_TICK_B = 8'b1000_0000
    } back_state_t;

    back_state_t        state_reg, state_next;
    pkm_op_t            op_reg, op_next;
    logic [SLOT_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [30:0]        pkt_cnt_reg, pkt_cnt_next;
    logic [30:0]        pair_cnt_reg, pair_cnt_next;
    logic [30:0]        rep_cnt_reg, rep_cnt_next;
    logic [31:0]        prev_loss_reg, prev_loss_next;
    logic [31:0]        peak_reg, peak_next;
    logic signed [63:0] win_min_reg, win_min_next;
    logic signed [63:0] win_max_reg, win_max_next;
    logic               restart_reg, restart_next;
    logic               match_n_reg, match_n_next;
    logic               match_p_reg, match_p_next;
    logic signed [63:0] delay_n_reg, delay_n_next;
    logic signed [63:0] delay_p_reg, delay_p_next;
    logic [31:0]        loss_reg, loss_next;
    logic [31:0]        jit_reg, jit_next;
    logic [30:0]        fresh_reg, fresh_next;
    logic               rpt_valid_reg, rpt_valid_next;
    logic [30:0]        tot_out_reg, tot_out_next;
    logic [30:0]        new_out_reg, new_out_next;
    logic [31:0]        loss_out_reg, loss_out_next;
    logic [31:0]        chg_out_reg, chg_out_next;
    logic [31:0]        peak_out_reg, peak_out_next;
    logic [31:0]        jit_out_reg, jit_out_next;

    logic [SLOT_W-1:0]  slot, slot_nxt, slot_prv;
    logic               ram_we;
    logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
    pkm_entry_t         ram_wdata, ram_rdata;
    logic               take;
    logic signed [63:0] take_delay;
    logic signed [32:0] dl;
    logic [31:0]        dl_sat;
    logic               out_free;

    pkm_ram #(
        .WIDTH ($bits(pkm_entry_t)),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Ring neighbours of this slot
    assign slot     = op_reg.slot[SLOT_W-1:0];
    assign slot_nxt = (slot == SLOT_LAST) ? '0 : slot + 1'b1;
    assign slot_prv = (slot == '0) ? SLOT_LAST : slot - 1'b1;
    assign ram_raddr = (state_reg == B_RD_PRV) ? slot_prv : slot_nxt;

    // Ring writes: clearing sweep, then one write per packet
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = slot;
        ram_wdata = '{filled: 1'b1, seq: op_reg.seq, send: op_reg.send, recv: op_reg.recv};
        if (state_reg == B_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
        end
        else if (state_reg == B_PAIR_P)
        begin
            ram_we = 1'b1;
        end
    end

    // Pair that updates the window this cycle
    assign take       = ((state_reg == B_PAIR_N) && match_n_reg) ||
                        ((state_reg == B_PAIR_P) && match_p_reg);
    assign take_delay = (state_reg == B_PAIR_N) ? delay_n_reg : delay_p_reg;

    // Loss change with signed saturation
    assign dl     = {loss_reg[31], loss_reg} - {prev_loss_reg[31], prev_loss_reg};
    assign dl_sat = (dl[32] != dl[31]) ? (dl[32] ? SAT_NEG : SAT_POS) : dl[31:0];

    assign out_free = !rpt_valid_reg || !rpt_stall;
    assign clearing = (state_reg == B_CLEAR);
    assign q_pop    = (state_reg == B_IDLE) && !q_empty;

    assign rpt_valid     = rpt_valid_reg;
    assign total_packets = tot_out_reg;
    assign new_packets   = new_out_reg;
    assign loss          = loss_out_reg;
    assign loss_change   = chg_out_reg;
    assign jitter_peak   = peak_out_reg;
    assign jitter_window = jit_out_reg;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        clr_cnt_next   = clr_cnt_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        pair_cnt_next  = pair_cnt_reg;
        rep_cnt_next   = rep_cnt_reg;
        prev_loss_next = prev_loss_reg;
        peak_next      = peak_reg;
        win_min_next   = win_min_reg;
        win_max_next   = win_max_reg;
        restart_next   = restart_reg;
        match_n_next   = match_n_reg;
        match_p_next   = match_p_reg;
        delay_n_next   = delay_n_reg;
        delay_p_next   = delay_p_reg;
        loss_next      = loss_reg;
        jit_next       = jit_reg;
        fresh_next     = fresh_reg;
        rpt_valid_next = rpt_valid_reg && rpt_stall;
        tot_out_next   = tot_out_reg;
        new_out_next   = new_out_reg;
        loss_out_next  = loss_out_reg;
        chg_out_next   = chg_out_reg;
        peak_out_next  = peak_out_reg;
        jit_out_next   = jit_out_reg;

        // Window update for a found pair
        if (take)
        begin
            pair_cnt_next = sat_inc31(pair_cnt_reg);
            if (take_delay < win_min_reg)
            begin
                win_min_next = take_delay;
            end
            if (take_delay > win_max_reg)
            begin
                win_max_next = take_delay;
            end
        end

        unique case (state_reg)
            B_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_LAST)
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    op_next = q_data;
                    if (q_data.is_tick)
                    begin
                        state_next = B_TICK_A;
                    end
                    else
                    begin
                        if (restart_reg)
                        begin
                            restart_next = 1'b0;
                            win_min_next = WIN_MIN_RESET;
                            win_max_next = WIN_MAX_RESET;
                        end
                        pkt_cnt_next = sat_inc31(pkt_cnt_reg);
                        state_next   = B_RD_NXT;
                    end
                end
            end
            B_RD_NXT:
            begin
                state_next = B_RD_PRV;
            end
            B_RD_PRV:
            begin
                // next slot data is back
                match_n_next = ram_rdata.filled &&
                               ({1'b0, op_reg.seq} + 32'd1 == {1'b0, ram_rdata.seq});
                delay_n_next = signed'({1'b0, op_reg.recv} - {1'b0, ram_rdata.send});
                state_next   = B_PAIR_N;
            end
            B_PAIR_N:
            begin
                // previous slot data is back
                match_p_next = ram_rdata.filled &&
                               ({1'b0, ram_rdata.seq} + 32'd1 == {1'b0, op_reg.seq});
                delay_p_next = signed'({1'b0, ram_rdata.recv} - {1'b0, op_reg.send});
                state_next   = B_PAIR_P;
            end
            B_PAIR_P:
            begin
                state_next = B_IDLE;
            end
            B_TICK_A:
            begin
                if (rep_cnt_reg == pkt_cnt_reg)
                begin
                    state_next = B_IDLE;
                end
                else
                begin
                    loss_next  = {1'b0, pkt_cnt_reg} - 32'd1 - {1'b0, pair_cnt_reg};
                    jit_next   = 32'(win_max_reg - win_min_reg);
                    fresh_next = pkt_cnt_reg - rep_cnt_reg;
                    state_next = B_TICK_B;
                end
            end
            B_TICK_B:
            begin
                if (out_free)
                begin
                    if ($signed(peak_reg) < $signed(jit_reg))
                    begin
                        peak_next     = jit_reg;
                        peak_out_next = jit_reg;
                    end
                    else
                    begin
                        peak_out_next = peak_reg;
                    end
                    prev_loss_next = loss_reg;
                    restart_next   = 1'b1;
                    rep_cnt_next   = pkt_cnt_reg;
                    rpt_valid_next = 1'b1;
                    tot_out_next   = pkt_cnt_reg;
                    new_out_next   = fresh_reg;
                    loss_out_next  = loss_reg;
                    chg_out_next   = dl_sat;
                    jit_out_next   = jit_reg;
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_cnt_reg   <= '0;
            pkt_cnt_reg   <= '0;
            pair_cnt_reg  <= '0;
            rep_cnt_reg   <= '0;
            prev_loss_reg <= '0;
            peak_reg      <= PEAK_RESET;
            win_min_reg   <= WIN_MIN_RESET;
            win_max_reg   <= WIN_MAX_RESET;
            restart_reg   <= 1'b1;
            match_n_reg   <= 1'b0;
            match_p_reg   <= 1'b0;
            rpt_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            pair_cnt_reg  <= pair_cnt_next;
            rep_cnt_reg   <= rep_cnt_next;
            prev_loss_reg <= prev_loss_next;
            peak_reg      <= peak_next;
            win_min_reg   <= win_min_next;
            win_max_reg   <= win_max_next;
            restart_reg   <= restart_next;
            match_n_reg   <= match_n_next;
            match_p_reg   <= match_p_next;
            rpt_valid_reg <= rpt_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        delay_n_reg  <= delay_n_next;
        delay_p_reg  <= delay_p_next;
        loss_reg     <= loss_next;
        jit_reg      <= jit_next;
        fresh_reg    <= fresh_next;
        tot_out_reg  <= tot_out_next;
        new_out_reg  <= new_out_next;
        loss_out_reg <= loss_out_next;
        chg_out_reg  <= chg_out_next;
        peak_out_reg <= peak_out_next;
        jit_out_reg  <= jit_out_next;
    end

endmodule
`default_nettype wire

// File: src/packet_loss_jitter_monitor_top.sv
// Packet loss and jitter monitor for one flow. Packet words (cmd 0) whose marker
// matches cfg_wr_data as last written (0x1234 after reset) go into a ring of
// RING_DEPTH slots by sequence number; each neighbour slot holding the adjacent
// sequence number counts a pair and feeds its delay into the window min and max.
// A tick word (cmd 1) produces one report word when packets arrived since the
// previous report. After reset the ring is cleared, one slot a cycle, and the
// block stalls until the clear is done, and only then takes its first word. The
// front steps a packet through F_MUL_Q and F_MUL_D (two multiplies give the
// slot) to F_PUSH; with one ring read port the back steps it through B_RD_NXT,
// B_RD_PRV, B_PAIR_N, B_PAIR_P (two neighbour reads, two window updates, one
// write), and a tick through B_TICK_A and B_TICK_B. A two-entry queue between
// them lets the front take a new word while the back works or a report waits.
`default_nettype none
module packet_loss_jitter_monitor_top
    import pkm_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        pkt_valid,
    output logic             pkt_stall,
    input  wire logic        cmd,
    input  wire logic [31:0] marker,
    input  wire logic [30:0] seq_num,
    input  wire logic [62:0] send_time,
    input  wire logic [62:0] recv_time,
    output logic             rpt_valid,
    input  wire logic        rpt_stall,
    output logic [30:0]      total_packets,
    output logic [30:0]      new_packets,
    output logic [31:0]      loss,
    output logic [31:0]      loss_change,
    output logic [31:0]      jitter_peak,
    output logic [31:0]      jitter_window
);

    logic [31:0] marker_value_reg;
    logic        clearing;
    logic        push_valid;
    pkm_op_t     push_data;
    logic        q_full;
    logic        q_empty;
    logic        q_pop;
    pkm_op_t     q_data;

    // Marker register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_value_reg <= MARKER_RESET;
        end
        else if (cfg_wr_en)
        begin
            marker_value_reg <= cfg_wr_data;
        end
    end

    pkm_front #(
        .RING_DEPTH (RING_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .marker_value (marker_value_reg),
        .hold         (clearing),
        .pkt_valid    (pkt_valid),
        .pkt_stall    (pkt_stall),
        .cmd          (cmd),
        .marker       (marker),
        .seq_num      (seq_num),
        .send_time    (send_time),
        .recv_time    (recv_time),
        .push_valid   (push_valid),
        .push_data    (push_data),
        .q_full       (q_full)
    );

    pkm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_data  (push_data),
        .full       (q_full),
        .pop        (q_pop),
        .pop_data   (q_data),
        .empty      (q_empty)
    );

    pkm_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .clearing      (clearing),
        .rpt_valid     (rpt_valid),
        .rpt_stall     (rpt_stall),
        .total_packets (total_packets),
        .new_packets   (new_packets),
        .loss          (loss),
        .loss_change   (loss_change),
        .jitter_peak   (jitter_peak),
        .jitter_window (jitter_window)
    );

    // No word is taken while the ring is being cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !(pkt_valid && !pkt_stall))
        else $error("word accepted during ring clear");

    // Nothing reaches the back while it is still clearing
    assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !q_pop)
        else $error("queue popped during ring clear");

    // A report always covers at least one new packet and never more than total
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> (new_packets != 31'd0) && (new_packets <= total_packets))
        else $error("report packet counts inconsistent");

    // Peak jitter is never below the window jitter it reports with
    assert property (@(posedge clk) disable iff (!rst_n)
        rpt_valid |-> ($signed(jitter_peak) >= $signed(jitter_window)))
        else $error("peak jitter below window jitter");

endmodule
`default_nettype wire

// File: verif/packet_loss_jitter_monitor_top_tb.sv
module packet_loss_jitter_monitor_top_tb;
    import pkm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RING          = RING_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 48;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_WORDS   = 160;

    localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [30:0] SEQ_TOP  = 31'h7FFF_FFFF;

    // One loss and jitter report
    typedef struct {
        logic [30:0] total_pk;
        logic [30:0] fresh_pk;
        logic [31:0] loss_v;
        logic [31:0] loss_delta;
        logic [31:0] peak_v;
        logic [31:0] window_v;
    } report_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [31:0] cfg_wr_data;
    logic        pkt_valid;
    logic        pkt_stall;
    logic        cmd;
    logic [31:0] marker;
    logic [30:0] seq_num;
    logic [62:0] send_time;
    logic [62:0] recv_time;
    logic        rpt_valid;
    logic        rpt_stall;
    logic [30:0] total_packets;
    logic [30:0] new_packets;
    logic [31:0] loss;
    logic [31:0] loss_change;
    logic [31:0] jitter_peak;
    logic [31:0] jitter_window;

    packet_loss_jitter_monitor_top #(
        .RING_DEPTH(RING)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pkt_valid(pkt_valid),
        .pkt_stall(pkt_stall),
        .cmd(cmd),
        .marker(marker),
        .seq_num(seq_num),
        .send_time(send_time),
        .recv_time(recv_time),
        .rpt_valid(rpt_valid),
        .rpt_stall(rpt_stall),
        .total_packets(total_packets),
        .new_packets(new_packets),
        .loss(loss),
        .loss_change(loss_change),
        .jitter_peak(jitter_peak),
        .jitter_window(jitter_window)
    );

    // Monitor state as the testbench sees it
    logic [31:0]        flow_marker;
    logic [30:0]        ring_seq    [RING];
    logic [62:0]        ring_send   [RING];
    logic [62:0]        ring_recv   [RING];
    bit                 ring_filled [RING];
    logic [30:0]        pkt_cnt;
    logic [30:0]        pair_cnt;
    logic [30:0]        reported_cnt;
    logic [31:0]        last_loss;
    logic [31:0]        peak_seen;
    logic signed [63:0] delay_lo;
    logic signed [63:0] delay_hi;
    bit                 window_fresh;

    report_t pending_reports[$];
    int      mismatches;
    int      burst_left;
    bit      hold_req;

    // Sequence and clock state of the random flow
    logic [30:0] flow_seq;
    logic [62:0] flow_clock;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("FAIL packet_loss_jitter_monitor_top");
        $finish;
    end

    function automatic logic [30:0] count_up(input logic [30:0] v);
        return (v == SEQ_TOP) ? v : v + 31'd1;
    endfunction

    // A consecutive pair: feed its delay into the window
    function automatic void take_delay(input logic [62:0] later_rcv,
                                       input logic [62:0] earlier_snd);
        logic signed [63:0] d;
        d = {1'b0, later_rcv} - {1'b0, earlier_snd};
        pair_cnt = count_up(pair_cnt);
        if (d < delay_lo)
            delay_lo = d;
        if (d > delay_hi)
            delay_hi = d;
    endfunction

    function automatic void clear_monitor();
        flow_marker  = MARKER_RESET;
        pkt_cnt      = '0;
        pair_cnt     = '0;
        reported_cnt = '0;
        last_loss    = '0;
        peak_seen    = PEAK_RESET;
        delay_lo     = WIN_MIN_RESET;
        delay_hi     = WIN_MAX_RESET;
        window_fresh = 1'b1;
        for (int i = 0; i < RING; i++)
            ring_filled[i] = 1'b0;
    endfunction

    // Update the monitor state for one accepted word, queue any report
    function automatic void track_word(input logic c, input logic [31:0] mk,
                                       input logic [30:0] sq,
                                       input logic [62:0] snd,
                                       input logic [62:0] rcv);
        int                 slot;
        int                 nxt;
        int                 prv;
        logic [31:0]        cur_loss;
        logic [63:0]        spread;
        logic signed [63:0] cur_s;
        logic signed [63:0] last_s;
        logic signed [63:0] dl;
        report_t            r;
        if (c == CMD_PACKET)
        begin
            if (mk != flow_marker)
                return;
            if (window_fresh)
            begin
                window_fresh = 1'b0;
                delay_lo     = WIN_MIN_RESET;
                delay_hi     = WIN_MAX_RESET;
            end
            pkt_cnt = count_up(pkt_cnt);
            slot = sq % RING;
            ring_seq[slot]    = sq;
            ring_send[slot]   = snd;
            ring_recv[slot]   = rcv;
            ring_filled[slot] = 1'b1;
            nxt = (slot + 1) % RING;
            prv = (slot + RING - 1) % RING;
            // 32-bit compare: the top sequence number has no successor
            if (ring_filled[nxt] && ({1'b0, sq} + 32'd1 == {1'b0, ring_seq[nxt]}))
                take_delay(rcv, ring_send[nxt]);
            if (ring_filled[prv] && ({1'b0, ring_seq[prv]} + 32'd1 == {1'b0, sq}))
                take_delay(ring_recv[prv], snd);
            return;
        end
        if (reported_cnt == pkt_cnt)
            return;
        cur_loss = {1'b0, pkt_cnt} - 32'd1 - {1'b0, pair_cnt};
        spread   = delay_hi - delay_lo;
        cur_s    = 64'($signed(cur_loss));
        last_s   = 64'($signed(last_loss));
        dl       = cur_s - last_s;
        if (dl > 64'sd2147483647)
            dl = 64'sd2147483647;
        if (dl < -64'sd2147483648)
            dl = -64'sd2147483648;
        if ($signed(peak_seen) < $signed(spread[31:0]))
            peak_seen = spread[31:0];
        r.total_pk   = pkt_cnt;
        r.fresh_pk   = pkt_cnt - reported_cnt;
        r.loss_v     = cur_loss;
        r.loss_delta = dl[31:0];
        r.peak_v     = peak_seen;
        r.window_v   = spread[31:0];
        last_loss    = cur_loss;
        window_fresh = 1'b1;
        reported_cnt = pkt_cnt;
        pending_reports.push_back(r);
    endfunction

    function automatic void note_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (want !== got)
        begin
            if (mismatches < 10)
                $display("%0t report %s: expected %h, got %h", $realtime, name, want, got);
            mismatches++;
        end
    endfunction

    // Report checker
    always @(posedge clk)
    begin : report_check
        report_t want;
        if (rst_n && rpt_valid && !rpt_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                if (mismatches < 10)
                    $display("%0t report with none pending: total %h", $realtime,
                             total_packets);
                mismatches++;
            end
            else
            begin
                want = pending_reports.pop_front();
                note_field("total_packets", {1'b0, want.total_pk}, {1'b0, total_packets});
                note_field("new_packets", {1'b0, want.fresh_pk}, {1'b0, new_packets});
                note_field("loss", want.loss_v, loss);
                note_field("loss_change", want.loss_delta, loss_change);
                note_field("jitter_peak", want.peak_v, jitter_peak);
                note_field("jitter_window", want.window_v, jitter_window);
            end
        end
    end

    // Report side stall: random modes, plus a long hold-off on request
    initial
    begin : report_stall_gen
        int         mode;
        int         span;
        int         hold_left;
        logic [7:0] pattern;
        mode      = 0;
        span      = 0;
        hold_left = 0;
        pattern   = 8'h00;
        rpt_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rpt_stall <= 1'b1;
            end
            else
            begin
                if (span == 0)
                begin
                    mode    = $urandom_range(0, 3);
                    span    = $urandom_range(8, 80);
                    pattern = 8'($urandom);
                end
                span--;
                case (mode)
                    0: rpt_stall <= 1'b0;
                    1: rpt_stall <= 1'($urandom_range(0, 1));
                    2: rpt_stall <= ($urandom_range(0, 9) < 8);
                    default: rpt_stall <= pattern[span % 8];
                endcase
            end
        end
    end

    // Offer one word and wait for it to be taken; bursts with random gaps
    task automatic send_word(input logic c, input logic [31:0] mk,
                             input logic [30:0] sq, input logic [62:0] snd,
                             input logic [62:0] rcv);
        int gap;
        pkt_valid <= 1'b1;
        cmd       <= c;
        marker    <= mk;
        seq_num   <= sq;
        send_time <= snd;
        recv_time <= rcv;
        @(posedge clk);
        while (pkt_stall)
            @(posedge clk);
        track_word(c, mk, sq, snd, rcv);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            pkt_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_packet(input logic [30:0] sq, input logic [62:0] snd,
                               input logic [62:0] rcv);
        send_word(CMD_PACKET, flow_marker, sq, snd, rcv);
    endtask

    // Tick with junk in the ignored fields
    task automatic send_tick();
        send_word(CMD_TICK, $urandom, 31'($urandom), 63'({$urandom, $urandom}),
                  63'({$urandom, $urandom}));
    endtask

    // Wait until every report is in and the block has gone quiet
    task automatic settle();
        pkt_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_marker(input logic [31:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        flow_marker = v;
    endtask

    // Empty window, pairs on both sides, window restart, idle tick
    task automatic test_reset_window();
        send_tick();
        send_packet(31'd100, 63'd1000, 63'd1500);
        send_tick();
        send_word(CMD_PACKET, flow_marker ^ 32'd1, 31'd101, 63'd5, 63'd6);
        send_packet(31'd101, 63'd2000, 63'd2600);
        send_packet(31'd99, 63'd0, 63'd700);
        send_tick();
        send_tick();
        send_packet(31'd102, 63'd3000, 63'd2900);
        send_tick();
    endtask

    // Top sequence numbers and extreme timestamps
    task automatic test_seq_top();
        send_packet(SEQ_TOP - 31'd2, 63'd5, 63'd0);
        send_packet(SEQ_TOP - 31'd1, TIME_MAX, TIME_MAX);
        send_packet(SEQ_TOP, 63'd0, 63'd12345);
        send_packet(31'h7FFF_FC00, 63'd7, 63'd9);
        send_packet(31'd0, TIME_MAX, 63'd0);
        send_tick();
    endtask

    // Marker register at both extremes, then back to its reset value
    task automatic test_marker_setting();
        write_marker(32'h0000_0000);
        send_packet(31'd500, 63'd100, 63'd180);
        send_word(CMD_PACKET, MARKER_RESET, 31'd501, 63'd200, 63'd260);
        send_tick();
        write_marker(32'hFFFF_FFFF);
        send_packet(31'd501, 63'd200, 63'd290);
        send_word(CMD_PACKET, 32'h0000_0000, 31'd502, 63'd300, 63'd330);
        send_tick();
        write_marker(MARKER_RESET);
    endtask

    // Long report hold-off while packets and ticks keep coming
    task automatic test_backpressure();
        settle();
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
        begin
            send_packet(31'(2000 + i), 63'(10000 + 100 * i), 63'(10050 + 97 * i));
            send_tick();
        end
        settle();
    endtask

    // Mostly in-order flows with loss, reordering, duplicates and noise
    task automatic test_random_flow();
        int          pick;
        int          step;
        logic [62:0] snd;
        logic [62:0] rcv;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph)
                0: write_marker(MARKER_RESET);
                1: write_marker($urandom);
                2: write_marker(32'hFFFF_FFFF);
                3: write_marker(32'h0000_0000);
                default: write_marker($urandom);
            endcase
            flow_seq   = 31'($urandom);
            flow_clock = ($urandom_range(0, 1) == 0) ? 63'($urandom_range(0, 100000))
                                                     : 63'({$urandom, $urandom});
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 7)
                    send_tick();
                else if (pick < 15)
                    send_word(CMD_PACKET, $urandom, 31'($urandom),
                              63'({$urandom, $urandom}), 63'({$urandom, $urandom}));
                else
                begin
                    step = $urandom_range(0, 99);
                    if (step < 75)
                        flow_seq = flow_seq + 31'd1;
                    else if (step < 85)
                        flow_seq = flow_seq + 31'($urandom_range(2, 4));
                    else if (step < 92)
                        flow_seq = flow_seq - 31'($urandom_range(1, 3));
                    else if (step < 96)
                        flow_seq = flow_seq;
                    else
                        flow_seq = 31'($urandom);
                    if ($urandom_range(0, 24) == 0)
                    begin
                        snd = 63'({$urandom, $urandom});
                        rcv = 63'({$urandom, $urandom});
                    end
                    else
                    begin
                        snd        = flow_clock;
                        rcv        = flow_clock + 63'($urandom_range(0, 3000));
                        flow_clock = flow_clock + 63'($urandom_range(1, 2000));
                    end
                    send_packet(flow_seq, snd, rcv);
                end
            end
        end
    endtask

    initial
    begin : main_seq
        int waited;
        mismatches  = 0;
        burst_left  = 0;
        hold_req    = 1'b0;
        clear_monitor();
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        pkt_valid   <= 1'b0;
        cmd         <= CMD_PACKET;
        marker      <= '0;
        seq_num     <= '0;
        send_time   <= '0;
        recv_time   <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_window();
        test_seq_top();
        test_marker_setting();
        test_backpressure();
        test_random_flow();

        // Drain, bounded
        pkt_valid <= 1'b0;
        waited = 0;
        while (pending_reports.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_reports.size() == 0)
            $display("PASS packet_loss_jitter_monitor_top");
        else
            $display("FAIL packet_loss_jitter_monitor_top");
        $finish;
    end

endmodule

// File: filelist.f
src/pkm_pkg.sv
src/pkm_ram.sv
src/pkm_queue.sv
src/pkm_front.sv
src/pkm_back.sv
src/packet_loss_jitter_monitor_top.sv
verif/packet_loss_jitter_monitor_top_tb.sv
